/* rtl/prcu_pkg.sv */
// ----------------------------------------------------------------------------
// Region permission check unit package
// Shared constants, function codes and the permission test.
// ----------------------------------------------------------------------------
package prcu_pkg;

	localparam int unsigned MAX_REGIONS_DEF = 16;
	localparam int unsigned ADDR_BITS_DEF   = 48;

	localparam int unsigned IDX_W  = 4;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned PERM_W = 3;
	localparam int unsigned LANE_W = 9;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [PERM_W-1:0] PERM_READ  = 3'd4;
	localparam logic [PERM_W-1:0] PERM_WRITE = 3'd2;
	localparam logic [PERM_W-1:0] PERM_EXEC  = 3'd1;

	function automatic logic grants(input logic [PERM_W-1:0] have,
		input logic [PERM_W-1:0] want);
		logic [PERM_W-1:0] all_bits;
		all_bits = PERM_READ | PERM_WRITE | PERM_EXEC;
		return ((want & ~have & all_bits) == '0);
	endfunction

endpackage

/* rtl/region_permission_check_unit.sv */
// ----------------------------------------------------------------------------
// Region permission check unit
// Region table loaded by write transactions; queries return found/allowed.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while in_stall is low. A region write
// updates the table as it leaves stage 1 and gives no result; a query's
// result passes stage 1, compare and select to out_valid. Every region has
// its own start/end comparator lane, so the rate does not depend on the table
// size; an output stall holds the waiting result and occupied stages behind it.
module region_permission_check_unit #(
	parameter int unsigned MAX_REGIONS = prcu_pkg::MAX_REGIONS_DEF,
	parameter int unsigned ADDR_BITS   = prcu_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [prcu_pkg::CNT_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [prcu_pkg::IDX_W-1:0]      entry_index,
	input  logic [ADDR_BITS-1:0]            entry_start,
	input  logic [ADDR_BITS-1:0]            entry_end,
	input  logic [prcu_pkg::PERM_W-1:0]     entry_perms,
	input  logic [ADDR_BITS-1:0]            query_addr,
	input  logic [prcu_pkg::PERM_W-1:0]     query_access,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic                            allowed
);

	logic [prcu_pkg::CNT_W-1:0] regions_in_use_q;

	logic                        v_s1, v_s2, v_s3;
	logic                        func_s1;
	logic [prcu_pkg::IDX_W-1:0]  idx_s1;
	logic [ADDR_BITS-1:0]        start_s1;
	logic [ADDR_BITS-1:0]        end_s1;
	logic [prcu_pkg::PERM_W-1:0] perms_s1;
	logic [ADDR_BITS-1:0]        addr_s1;
	logic [prcu_pkg::PERM_W-1:0] access_s1;

	logic [MAX_REGIONS-1:0] above_s2, inside_s2, grant_s2;
	logic                   found_s3, allowed_s3;

	logic ld1, ld2, ld3;
	logic wr_en;

	assign ld3   = !v_s3 || !out_stall;
	assign ld2   = !v_s2 || ld3;
	assign ld1   = !v_s1 || ld2;
	assign wr_en = v_s1 && (func_s1 == prcu_pkg::FUNC_WRITE) && ld2;

	assign in_stall  = !ld1;
	assign out_valid = v_s3;
	assign found     = found_s3;
	assign allowed   = allowed_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regions_in_use_q <= '0;
		end else if (cfg_we) begin
			regions_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= in_valid;
			end
			if (ld2) begin
				v_s2 <= v_s1 && (func_s1 == prcu_pkg::FUNC_QUERY);
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			func_s1   <= func;
			idx_s1    <= entry_index;
			start_s1  <= entry_start;
			end_s1    <= entry_end;
			perms_s1  <= entry_perms;
			addr_s1   <= query_addr;
			access_s1 <= query_access;
		end
	end

	prcu_region_table #(
		.MAX_REGIONS(MAX_REGIONS),
		.ADDR_BITS  (ADDR_BITS)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_idx   (idx_s1),
		.wr_start (start_s1),
		.wr_end   (end_s1),
		.wr_perms (perms_s1),
		.ld       (ld2),
		.q_addr   (addr_s1),
		.q_access (access_s1),
		.count    (regions_in_use_q),
		.above_s2 (above_s2),
		.inside_s2(inside_s2),
		.grant_s2 (grant_s2)
	);

	prcu_priority_select #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_select (
		.clk       (clk),
		.ld        (ld3),
		.above_s2  (above_s2),
		.inside_s2 (inside_s2),
		.grant_s2  (grant_s2),
		.found_s3  (found_s3),
		.allowed_s3(allowed_s3)
	);

`ifndef SYNTHESIS
	a_allowed_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (!allowed_s3 || found_s3))
		else $error("allowed without found");

	a_write_gives_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (func_s1 == prcu_pkg::FUNC_WRITE) && ld2) |=> !v_s2)
		else $error("write transaction entered the compare stage");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s2 && !v_s3) |=> !v_s3)
		else $error("result appeared without a query");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_stall) |=> (v_s3 && $stable(found_s3) && $stable(allowed_s3)))
		else $error("stalled result changed");
`endif

endmodule

/* rtl/prcu_region_table.sv */
// ----------------------------------------------------------------------------
// Region table and comparator lanes
// Holds the region entries and compares a query against every entry at once.
// ----------------------------------------------------------------------------
module prcu_region_table #(
	parameter int unsigned MAX_REGIONS = prcu_pkg::MAX_REGIONS_DEF,
	parameter int unsigned ADDR_BITS   = prcu_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [prcu_pkg::IDX_W-1:0]      wr_idx,
	input  logic [ADDR_BITS-1:0]            wr_start,
	input  logic [ADDR_BITS-1:0]            wr_end,
	input  logic [prcu_pkg::PERM_W-1:0]     wr_perms,
	input  logic                            ld,
	input  logic [ADDR_BITS-1:0]            q_addr,
	input  logic [prcu_pkg::PERM_W-1:0]     q_access,
	input  logic [prcu_pkg::CNT_W-1:0]      count,
	output logic [MAX_REGIONS-1:0]          above_s2,
	output logic [MAX_REGIONS-1:0]          inside_s2,
	output logic [MAX_REGIONS-1:0]          grant_s2
);

	logic [ADDR_BITS-1:0]        start_q [MAX_REGIONS];
	logic [ADDR_BITS-1:0]        end_q   [MAX_REGIONS];
	logic [prcu_pkg::PERM_W-1:0] rights_q[MAX_REGIONS];

	logic [prcu_pkg::LANE_W-1:0] idx_ext;
	logic [prcu_pkg::LANE_W-1:0] cnt_ext;

	assign idx_ext = prcu_pkg::LANE_W'(wr_idx);
	assign cnt_ext = prcu_pkg::LANE_W'(count);

	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_lane
		localparam logic [prcu_pkg::LANE_W-1:0] LANE = prcu_pkg::LANE_W'(i);

		logic sel_wr;
		logic in_use;

		assign sel_wr = wr_en && (idx_ext == LANE);
		assign in_use = LANE < cnt_ext;

		always_ff @(posedge clk) begin
			if (sel_wr) begin
				start_q[i]  <= wr_start;
				end_q[i]    <= wr_end;
				rights_q[i] <= wr_perms;
			end
		end

		always_ff @(posedge clk) begin
			if (ld) begin
				above_s2[i]  <= in_use && (q_addr < end_q[i]);
				inside_s2[i] <= start_q[i] <= q_addr;
				grant_s2[i]  <= prcu_pkg::grants(rights_q[i], q_access);
			end
		end
	end

endmodule

/* rtl/prcu_priority_select.sv */
// ----------------------------------------------------------------------------
// Region priority select
// Picks the lowest in-use region ending above the address and forms the result.
// ----------------------------------------------------------------------------
module prcu_priority_select #(
	parameter int unsigned MAX_REGIONS = prcu_pkg::MAX_REGIONS_DEF
) (
	input  logic                   clk,
	input  logic                   ld,
	input  logic [MAX_REGIONS-1:0] above_s2,
	input  logic [MAX_REGIONS-1:0] inside_s2,
	input  logic [MAX_REGIONS-1:0] grant_s2,
	output logic                   found_s3,
	output logic                   allowed_s3
);

	logic [MAX_REGIONS-1:0] first;
	logic [MAX_REGIONS-1:0] hit;

	assign first = above_s2 & (~above_s2 + MAX_REGIONS'(1));
	assign hit   = first & inside_s2;

	always_ff @(posedge clk) begin
		if (ld) begin
			found_s3   <= |hit;
			allowed_s3 <= |(hit & grant_s2);
		end
	end

endmodule
